// ----- sv/serial_frame_receiver_top_defines.svh -----
// Assertion macros for the serial frame receiver.
// Used by serial_frame_receiver_top; expects clk and rst_n in scope.
`ifndef SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sfr_pkg.sv -----
// Shared types and constants for the serial frame receiver.
// No dependencies.
`default_nettype none

package sfr_pkg;

    localparam int DATA_W = 8;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 2;

    localparam logic [DATA_W-1:0] DEVICE_ID_SINGLE = 8'd1;

    localparam logic [CFG_W-1:0] REG_OWN_ID       = 2'd0;
    localparam logic [CFG_W-1:0] REG_PEER_ID_A    = 2'd1;
    localparam logic [CFG_W-1:0] REG_PEER_ID_B    = 2'd2;
    localparam logic [CFG_W-1:0] REG_BROADCAST_ID = 2'd3;

    localparam logic [DATA_W-1:0] OWN_ID_RST       = 8'd172;
    localparam logic [DATA_W-1:0] PEER_ID_A_RST    = 8'd184;
    localparam logic [DATA_W-1:0] PEER_ID_B_RST    = 8'd183;
    localparam logic [DATA_W-1:0] BROADCAST_ID_RST = 8'd254;

    typedef enum logic [8:0] {
        ST_OWN  = 9'b000000001,
        ST_PEER = 9'b000000010,
        ST_DEV  = 9'b000000100,
        ST_TYPE = 9'b000001000,
        ST_LEN  = 9'b000010000,
        ST_PAY  = 9'b000100000,
        ST_SUM  = 9'b001000000,
        ST_RD   = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

// ----- sv/serial_frame_receiver_top.sv -----
// Serial frame receiver top level: parser, payload memory and result drain.
// Depends on sfr_pkg and serial_frame_receiver_top_defines.svh.
`default_nettype none
`include "serial_frame_receiver_top_defines.svh"

// Parses frames (own id, sender id, device id, type, length, payload,
// checksum) from a byte stream at one byte per cycle outside the payload
// drain. Payload bytes go into a PAYLOAD_LIMIT-entry memory. After a checksum
// byte that brings the 8-bit sum to zero, the stored payload drains as one
// result per byte, each via a memory read state and an output load state,
// while rx input is held off; the next byte is taken as soon as the last
// result sits in the output register. Bad frames leave no result. The memory
// needs no clearing after reset, so the block is ready right out of reset.
module serial_frame_receiver_top
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_LIMIT = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] rx_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      packet_type,
    output logic [DATA_W-1:0]      declared_length,
    output logic [IDX_W-1:0]       byte_index,
    output logic [DATA_W-1:0]      payload_byte,
    output logic                   last_byte
);

    localparam int AW    = (PAYLOAD_LIMIT > 2) ? $clog2(PAYLOAD_LIMIT) : 1;
    localparam int CNT_W = $clog2(PAYLOAD_LIMIT + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(PAYLOAD_LIMIT);

    state_t state_reg, state_next;

    logic [DATA_W-1:0] own_id_reg, peer_a_reg, peer_b_reg, bcast_reg;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [DATA_W-1:0] type_reg, type_next;
    logic [DATA_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_type_reg, out_len_reg, out_data_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_last_reg;

    logic [DATA_W-1:0] mem [PAYLOAD_LIMIT];
    logic [DATA_W-1:0] rd_data_reg;

    logic              in_xfer, mem_we, mem_re, out_load, rd_last;
    logic [DATA_W-1:0] sum_add;
    logic [CNT_W-1:0]  cnt_inc, rd_idx_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg != ST_RD) && (state_reg != ST_OUT);
    assign in_xfer   = in_valid && in_ready;
    assign sum_add   = sum_reg + rx_byte;
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign rd_idx_inc = rd_idx_reg + CNT_W'(1);
    assign rd_last   = (rd_idx_inc == cnt_reg);
    assign mem_we    = in_xfer && (state_reg == ST_PAY);
    assign mem_re    = (state_reg == ST_RD);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        case (state_reg)
            ST_OWN:
            begin
                if (in_xfer && rx_byte == own_id_reg)
                begin
                    sum_next   = rx_byte;
                    state_next = ST_PEER;
                end
            end
            ST_PEER:
            begin
                if (in_xfer)
                begin
                    if (rx_byte == peer_a_reg || rx_byte == peer_b_reg)
                    begin
                        sum_next   = sum_add;
                        state_next = ST_DEV;
                    end
                    else
                    begin
                        state_next = ST_OWN;
                    end
                end
            end
            ST_DEV:
            begin
                if (in_xfer)
                begin
                    if (rx_byte == DEVICE_ID_SINGLE || rx_byte == bcast_reg)
                    begin
                        sum_next   = sum_add;
                        state_next = ST_TYPE;
                    end
                    else
                    begin
                        state_next = ST_OWN;
                    end
                end
            end
            ST_TYPE:
            begin
                if (in_xfer)
                begin
                    sum_next   = sum_add;
                    type_next  = rx_byte;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (in_xfer)
                begin
                    sum_next   = sum_add;
                    len_next   = rx_byte;
                    cnt_next   = '0;
                    state_next = ST_PAY;
                end
            end
            ST_PAY:
            begin
                if (in_xfer)
                begin
                    sum_next = sum_add;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= CNT_LIMIT)
                    begin
                        state_next = ST_OWN;
                    end
                    else if (DATA_W'(cnt_inc) >= len_reg)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (in_xfer)
                begin
                    sum_next    = sum_add;
                    rd_idx_next = '0;
                    state_next  = (sum_add == '0) ? ST_RD : ST_OWN;
                end
            end
            ST_RD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    rd_idx_next = rd_idx_inc;
                    state_next  = rd_last ? ST_OWN : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_OWN;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_OWN;
            sum_reg       <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            own_id_reg    <= OWN_ID_RST;
            peer_a_reg    <= PEER_ID_A_RST;
            peer_b_reg    <= PEER_ID_B_RST;
            bcast_reg     <= BROADCAST_ID_RST;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OWN_ID:       own_id_reg <= cfg_data;
                    REG_PEER_ID_A:    peer_a_reg <= cfg_data;
                    REG_PEER_ID_B:    peer_b_reg <= cfg_data;
                    REG_BROADCAST_ID: bcast_reg  <= cfg_data;
                    default:          own_id_reg <= own_id_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[AW-1:0]] <= rx_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_type_reg <= type_reg;
            out_len_reg  <= len_reg;
            out_idx_reg  <= IDX_W'(rd_idx_reg);
            out_data_reg <= rd_data_reg;
            out_last_reg <= rd_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign packet_type     = out_type_reg;
    assign declared_length = out_len_reg;
    assign byte_index      = out_idx_reg;
    assign payload_byte    = out_data_reg;
    assign last_byte       = out_last_reg;

    `SFR_ASSERT_NOW(a_drain_blocks_input, (state_reg == ST_RD || state_reg == ST_OUT),
        !in_ready, "input taken during payload drain")
    `SFR_ASSERT_NOW(a_read_in_range, (state_reg == ST_RD || state_reg == ST_OUT),
        (rd_idx_reg < cnt_reg), "drain index past stored payload")
    `SFR_ASSERT_NOW(a_count_below_limit, (state_reg == ST_PAY),
        (cnt_reg < CNT_LIMIT), "payload count reached limit while storing")
    `SFR_ASSERT_NEXT(a_last_ends_drain, (out_load && rd_last),
        (state_reg == ST_OWN && out_valid_reg), "drain did not end on last result")

endmodule

`default_nettype wire
